FILE: src/rlegr_pkg.sv
// ----------------------------------------------------------------------------
// rlegr_pkg: shared types and constants for the logo span decoder
// Transaction structs of both channels, register map and color mode codes.
// ----------------------------------------------------------------------------
package rlegr_pkg;

   // input transaction: one run of the logo image
   typedef struct packed {
      logic [7:0] gray_level;
      logic [7:0] run_length;
   } req_type;

   // result transaction: one fill span
   typedef struct packed {
      logic [23:0] pixel_address;
      logic [7:0]  span_length;
      logic [15:0] pixel_color;
      logic        last_span;
      logic        image_done;
   } rsp_type;

   // register indexes (paddr[4:2])
   localparam logic [2:0] CSR_COLOR_MODE  = 3'd0;
   localparam logic [2:0] CSR_LOGO_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_LOGO_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_ROW_PITCH   = 3'd3;
   localparam logic [2:0] CSR_BASE_OFFSET = 3'd4;

   // color modes
   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_PURPLE = 2'd1;
   localparam logic [1:0] MODE_DARK   = 2'd2;

   // register reset values
   localparam logic [1:0]  RST_COLOR_MODE  = MODE_PLAIN;
   localparam logic [11:0] RST_LOGO_WIDTH  = 12'd8;
   localparam logic [11:0] RST_LOGO_HEIGHT = 12'd1;
   localparam logic [13:0] RST_ROW_PITCH   = 14'd8;
   localparam logic [23:0] RST_BASE_OFFSET = 24'd0;

   // narrowest logo row the decoder uses
   localparam int MIN_WIDTH = 8;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SPAN = 2'b10
   } state_type;

endpackage

FILE: src/rlegr_color.sv
// ----------------------------------------------------------------------------
// rlegr_color: gray level to rgb565 color map
// Plain gray, purple tint (inverted gray with clamped per-channel affine map)
// and dark inverted gray. Purely combinational; the caller registers it.
// ----------------------------------------------------------------------------
module rlegr_color (
   input  logic [1:0]  color_mode,
   input  logic [7:0]  gray_level,
   output logic [15:0] pixel_color
);
   import rlegr_pkg::*;

   localparam logic [7:0]         INV_BASE  = 8'd240;
   localparam logic [7:0]         DARK_BASE = 8'd120;
   localparam logic [17:0]        MUL_R     = 18'd848;
   localparam logic [17:0]        MUL_G     = 18'd768;
   localparam logic [17:0]        MUL_B     = 18'd341;
   localparam logic signed [11:0] OFS_R     = -12'sd330;
   localparam logic signed [11:0] OFS_G     = -12'sd343;
   localparam logic signed [11:0] OFS_B     = -12'sd91;

   function automatic logic [7:0] clamp8(input logic signed [11:0] x);
      logic [7:0] res;
      if (x < 12'sd0) begin
         res = 8'd0;
      end else if (x > 12'sd255) begin
         res = 8'd255;
      end else begin
         res = x[7:0];
      end
      return res;
   endfunction

   function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   logic [7:0]  inv;
   logic [17:0] prod_r;
   logic [17:0] prod_g;
   logic [17:0] prod_b;
   logic [7:0]  pur_r;
   logic [7:0]  pur_g;
   logic [7:0]  pur_b;
   logic [7:0]  dark_x;
   logic [9:0]  dark_5x;
   logic [7:0]  dark_g;

   always_comb begin
      inv    = INV_BASE - gray_level;
      prod_r = 18'(inv) * MUL_R;
      prod_g = 18'(inv) * MUL_G;
      prod_b = 18'(inv) * MUL_B;
      pur_r  = clamp8($signed({2'b00, prod_r[17:8]}) + OFS_R);
      pur_g  = clamp8($signed({2'b00, prod_g[17:8]}) + OFS_G);
      pur_b  = clamp8($signed({2'b00, prod_b[17:8]}) + OFS_B);

      // brighter than the pivot goes to black
      dark_x  = (gray_level <= DARK_BASE) ? (DARK_BASE - gray_level) : 8'd0;
      dark_5x = {dark_x, 2'b00} + 10'(dark_x);
      dark_g  = dark_5x[9:2];

      unique case (color_mode)
         MODE_PURPLE: begin
            pixel_color = pack565(pur_r, pur_g, pur_b);
         end
         MODE_DARK: begin
            pixel_color = pack565(dark_g, dark_g, dark_g);
         end
         default: begin
            pixel_color = pack565(gray_level, gray_level, gray_level);
         end
      endcase
   end

endmodule

FILE: src/rlegr_span_step.sv
// ----------------------------------------------------------------------------
// rlegr_span_step: one span of a run
// Shared step unit: clips the remaining run at the row end, forms the span
// address and advances column and line base. Used once per span cycle.
// ----------------------------------------------------------------------------
module rlegr_span_step #(
   parameter int ADDR_BITS = 24,
   parameter int DIM_BITS  = 12
) (
   input  logic [ADDR_BITS-1:0] line_base,
   input  logic [DIM_BITS-1:0]  column,
   input  logic [DIM_BITS-1:0]  width,
   input  logic [13:0]          row_pitch,
   input  logic [7:0]           left,
   output logic [ADDR_BITS-1:0] address,
   output logic [7:0]           span_length,
   output logic [7:0]           left_next,
   output logic [DIM_BITS-1:0]  column_next,
   output logic [ADDR_BITS-1:0] line_base_next
);
   import rlegr_pkg::*;

   logic [DIM_BITS-1:0] room;
   logic                fits;
   logic [DIM_BITS:0]   column_sum;
   logic                wrap;

   always_comb begin
      room        = width - column;
      fits        = DIM_BITS'(left) < room;
      // when the run does not fit, room is at most left and so fits in 8 bits
      span_length = fits ? left : room[7:0];
      left_next   = left - span_length;
      address     = line_base + ADDR_BITS'(column);
      column_sum  = (DIM_BITS + 1)'(column) + (DIM_BITS + 1)'(span_length);
      wrap        = column_sum >= (DIM_BITS + 1)'(width);
      column_next = wrap ? '0 : column_sum[DIM_BITS-1:0];
      line_base_next = wrap ? (line_base + ADDR_BITS'(row_pitch)) : line_base;
   end

endmodule

FILE: src/rle_gray_logo_to_rgb565_spans_unit.sv
// ----------------------------------------------------------------------------
// rle_gray_logo_to_rgb565_spans_unit: run-length logo decoder to fill spans
// Maps each run's gray level to rgb565 and splits the run at row ends into
// framebuffer spans, within a width times height pixel budget.
// ----------------------------------------------------------------------------
// usage:
//  - req channel: one transaction per run (gray level, run length). A run of
//    zero, or any run after the budget is used up, gives no result.
//  - rsp channel: one transaction per span; last_span marks a run's final span
//    and image_done is set on every span of the run that used up the budget.
//  - csr port: apb-style, register i at byte address 4*i, pready always high.
//    Any write to a known register restarts decoding from the new values.
//  - timing: a run is taken in the idle state, then the span step unit produces one
//    span per cycle into the output register while that register is free.
//    req_stall is high while spans of the current run are pending.
//  - a stalled rsp transaction holds the output register and the sequencer;
//    the next run is accepted while the last span still waits.
//  - reset and every register write take one restart cycle (loading the
//    budget product) during which req_stall is high.
// ----------------------------------------------------------------------------
module rle_gray_logo_to_rgb565_spans_unit #(
   parameter int ADDR_BITS = 24,
   parameter int DIM_BITS  = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rlegr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rlegr_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import rlegr_pkg::*;

   localparam int PIX_BITS = 2 * DIM_BITS;

   // configuration registers
   logic [1:0]  color_mode_ff,  color_mode_in;
   logic [11:0] logo_width_ff,  logo_width_in;
   logic [11:0] logo_height_ff, logo_height_in;
   logic [13:0] row_pitch_ff,   row_pitch_in;
   logic [23:0] base_offset_ff, base_offset_in;

   // decoder state
   state_type            state_ff, state_in;
   logic                 restart_ff, restart_in;
   logic [ADDR_BITS-1:0] line_base_ff, line_base_in;
   logic [DIM_BITS-1:0]  column_ff, column_in;
   logic [PIX_BITS-1:0]  pixels_left_ff, pixels_left_in;
   logic                 finished_ff, finished_in;
   logic [7:0]           left_ff, left_in;
   logic                 done_ff, done_in;
   logic [15:0]          color_ff, color_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 csr_write;
   logic [2:0]           csr_index;
   logic                 req_accept;
   logic                 out_free;
   logic [DIM_BITS-1:0]  width_raw;
   logic [DIM_BITS-1:0]  width_eff;
   logic [PIX_BITS-1:0]  run_ext;
   logic [15:0]          map_color;
   logic [ADDR_BITS-1:0] step_address;
   logic [7:0]           step_length;
   logic [7:0]           step_left;
   logic [DIM_BITS-1:0]  step_column;
   logic [ADDR_BITS-1:0] step_line_base;

   rlegr_color u_color (
      .color_mode  (color_mode_ff),
      .gray_level  (req_data.gray_level),
      .pixel_color (map_color)
   );

   rlegr_span_step #(
      .ADDR_BITS (ADDR_BITS),
      .DIM_BITS  (DIM_BITS)
   ) u_step (
      .line_base      (line_base_ff),
      .column         (column_ff),
      .width          (width_eff),
      .row_pitch      (row_pitch_ff),
      .left           (left_ff),
      .address        (step_address),
      .span_length    (step_length),
      .left_next      (step_left),
      .column_next    (step_column),
      .line_base_next (step_line_base)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];
   assign width_raw  = DIM_BITS'(logo_width_ff);
   assign width_eff  = (width_raw < DIM_BITS'(MIN_WIDTH)) ? DIM_BITS'(MIN_WIDTH) : width_raw;
   assign run_ext    = PIX_BITS'(req_data.run_length);
   assign req_stall  = (state_ff != ST_IDLE) || restart_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      unique case (csr_index)
         CSR_COLOR_MODE:  csr_prdata = 32'(color_mode_ff);
         CSR_LOGO_WIDTH:  csr_prdata = 32'(logo_width_ff);
         CSR_LOGO_HEIGHT: csr_prdata = 32'(logo_height_ff);
         CSR_ROW_PITCH:   csr_prdata = 32'(row_pitch_ff);
         CSR_BASE_OFFSET: csr_prdata = 32'(base_offset_ff);
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      color_mode_in  = color_mode_ff;
      logo_width_in  = logo_width_ff;
      logo_height_in = logo_height_ff;
      row_pitch_in   = row_pitch_ff;
      base_offset_in = base_offset_ff;
      state_in       = state_ff;
      restart_in     = 1'b0;
      line_base_in   = line_base_ff;
      column_in      = column_ff;
      pixels_left_in = pixels_left_ff;
      finished_in    = finished_ff;
      left_in        = left_ff;
      done_in        = done_ff;
      color_in       = color_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // restart cycle loads the state from the registers
      if (restart_ff) begin
         line_base_in   = ADDR_BITS'(base_offset_ff);
         column_in      = '0;
         pixels_left_in = PIX_BITS'(DIM_BITS'(logo_width_ff)) *
                          PIX_BITS'(DIM_BITS'(logo_height_ff));
         finished_in    = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && !finished_ff && (req_data.run_length != 8'd0)) begin
               if (run_ext >= pixels_left_ff) begin
                  pixels_left_in = '0;
                  finished_in    = 1'b1;
                  done_in        = 1'b1;
               end else begin
                  pixels_left_in = pixels_left_ff - run_ext;
                  done_in        = 1'b0;
               end
               left_in  = req_data.run_length;
               color_in = map_color;
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pixel_address = 24'(step_address);
               rsp_data_in.span_length   = step_length;
               rsp_data_in.pixel_color   = color_ff;
               rsp_data_in.last_span     = (step_left == 8'd0);
               rsp_data_in.image_done    = done_ff;
               left_in                   = step_left;
               column_in                 = step_column;
               line_base_in              = step_line_base;
               if (step_left == 8'd0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         unique case (csr_index)
            CSR_COLOR_MODE: begin
               color_mode_in = csr_pwdata[1:0];
               restart_in    = 1'b1;
            end
            CSR_LOGO_WIDTH: begin
               logo_width_in = csr_pwdata[11:0];
               restart_in    = 1'b1;
            end
            CSR_LOGO_HEIGHT: begin
               logo_height_in = csr_pwdata[11:0];
               restart_in     = 1'b1;
            end
            CSR_ROW_PITCH: begin
               row_pitch_in = csr_pwdata[13:0];
               restart_in   = 1'b1;
            end
            CSR_BASE_OFFSET: begin
               base_offset_in = csr_pwdata[23:0];
               restart_in     = 1'b1;
            end
            default: begin
               restart_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff  <= RST_COLOR_MODE;
         logo_width_ff  <= RST_LOGO_WIDTH;
         logo_height_ff <= RST_LOGO_HEIGHT;
         row_pitch_ff   <= RST_ROW_PITCH;
         base_offset_ff <= RST_BASE_OFFSET;
         state_ff       <= ST_IDLE;
         restart_ff     <= 1'b1;
         line_base_ff   <= '0;
         column_ff      <= '0;
         pixels_left_ff <= '0;
         finished_ff    <= 1'b0;
         left_ff        <= '0;
         done_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         color_mode_ff  <= color_mode_in;
         logo_width_ff  <= logo_width_in;
         logo_height_ff <= logo_height_in;
         row_pitch_ff   <= row_pitch_in;
         base_offset_ff <= base_offset_in;
         state_ff       <= state_in;
         restart_ff     <= restart_in;
         line_base_ff   <= line_base_in;
         column_ff      <= column_in;
         pixels_left_ff <= pixels_left_in;
         finished_ff    <= finished_in;
         left_ff        <= left_in;
         done_ff        <= done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff    <= color_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.span_length != 8'd0))
      else $error("span of zero length in output register");

   a_column_in_row: assert property (@(posedge clock) disable iff (reset)
      !restart_ff |-> (column_ff < width_eff))
      else $error("column beyond logo row");

   a_finished_empty: assert property (@(posedge clock) disable iff (reset)
      (finished_ff && !restart_ff) |-> (pixels_left_ff == '0))
      else $error("finished with pixels left");

   a_idle_no_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (left_ff == 8'd0))
      else $error("idle with run pixels pending");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPAN && out_free && step_left == 8'd0) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after last span");
`endif

endmodule
